// ===== rtl/core/multi_slot_alarm_escalation_macros.svh =====
`ifndef MULTI_SLOT_ALARM_ESCALATION_MACROS_SVH
`define MULTI_SLOT_ALARM_ESCALATION_MACROS_SVH

// Same-cycle implication, checked outside reset
`define MSE_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// Next-cycle implication, checked outside reset
`define MSE_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

// ===== rtl/core/mse_pkg.sv =====
`default_nettype none
package mse_pkg;

   // Alert levels
   localparam logic [1:0] LVL_IDLE      = 2'd0;
   localparam logic [1:0] LVL_ACTIVE    = 2'd1;
   localparam logic [1:0] LVL_ESCALATED = 2'd2;

   // Event kinds
   localparam logic [1:0] EV_NONE    = 2'd0;
   localparam logic [1:0] EV_ON_TIME = 2'd1;
   localparam logic [1:0] EV_LATE    = 2'd2;
   localparam logic [1:0] EV_MISSED  = 2'd3;

   // Time and limit constants
   localparam logic [16:0] SEC_PER_HOUR   = 17'd3600;
   localparam logic [16:0] SEC_PER_MINUTE = 17'd60;
   localparam logic [15:0] ESC_DEFAULT    = 16'd30;
   localparam logic [15:0] MISS_EXTRA     = 16'd60;
   localparam logic [4:0]  HOUR_MAX       = 5'd23;
   localparam logic [5:0]  MINUTE_MAX     = 6'd59;

   // Indicator settings
   localparam logic [9:0]  BLINK_ACTIVE    = 10'd1000;
   localparam logic [9:0]  BLINK_ESCALATED = 10'd300;
   localparam logic [10:0] TONE_ACTIVE     = 11'd1200;
   localparam logic [10:0] TONE_ESCALATED  = 11'd2000;

   // Stored slot entry; the enable bit lives in its own reset vector
   typedef struct packed {
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [15:0] esc;
      logic [15:0] miss;
   } slot_entry_type;

   // Compare results of the shared time unit
   typedef struct packed {
      logic [16:0] base;
      logic        reached;
      logic        within_esc;
      logic        past_esc;
      logic        past_miss;
   } time_res_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_EXEC  = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_CHECK = 5'b01000,
      ST_RESP  = 5'b10000
   } state_type;

   function automatic logic [9:0] blink_of(input logic [1:0] level);
      logic [9:0] period;
      case (level)
         LVL_ACTIVE:    period = BLINK_ACTIVE;
         LVL_ESCALATED: period = BLINK_ESCALATED;
         default:       period = 10'd0;
      endcase
      return period;
   endfunction

   function automatic logic [10:0] tone_of(input logic [1:0] level);
      logic [10:0] freq;
      case (level)
         LVL_ACTIVE:    freq = TONE_ACTIVE;
         LVL_ESCALATED: freq = TONE_ESCALATED;
         default:       freq = 11'd0;
      endcase
      return freq;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/mse_time_unit.sv =====
`default_nettype none
module mse_time_unit
   import mse_pkg::*;
(
   input  wire logic [16:0]    now,
   input  wire logic           use_due,
   input  wire logic [16:0]    due_run,
   input  wire slot_entry_type entry,
   output time_res_type        res
);

   logic [16:0] slot_due;
   logic [16:0] base;
   logic        reached;
   logic [16:0] elapsed;

   // Derive the slot's due second from hour and minute
   assign slot_due = (17'(entry.hour) * SEC_PER_HOUR) + (17'(entry.minute) * SEC_PER_MINUTE);

   // Pick the reference: running due time on a check, slot due time on a scan
   assign base    = use_due ? due_run : slot_due;
   assign reached = (now >= base);
   assign elapsed = reached ? (now - base) : 17'd0;

   assign res.base       = base;
   assign res.reached    = reached;
   assign res.within_esc = (elapsed <= {1'b0, entry.esc});
   assign res.past_esc   = (elapsed >= {1'b0, entry.esc});
   assign res.past_miss  = (elapsed >= {1'b0, entry.miss});

endmodule
`default_nettype wire

// ===== rtl/core/multi_slot_alarm_escalation.sv =====
// Sequence: a write passes through the capture, execute and response states; a tick with an
// alert running also passes the check state; an idle tick scans slots one per cycle, visiting
// 1 up to SLOT_COUNT slots serially through the shared time unit. One transaction at a time: a
// new request is taken only once the result is in the output register, which waits on rsp_ready.
// Reset (synchronous, active high): all slots disabled, fired marks cleared, no alert,
// previous second zero; slot payload fields are undefined until written.
`default_nettype none
`include "multi_slot_alarm_escalation_macros.svh"
module multi_slot_alarm_escalation
   import mse_pkg::*;
#(
   parameter int SLOT_COUNT = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_mode,
   input  wire logic [16:0] req_time_s,
   input  wire logic        req_acknowledge,
   input  wire logic [2:0]  req_slot_number,
   input  wire logic [4:0]  req_slot_hour,
   input  wire logic [5:0]  req_slot_minute,
   input  wire logic [15:0] req_escalate_delay,
   input  wire logic [15:0] req_miss_delay,
   input  wire logic        req_slot_enable,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_alert_level,
   output logic [1:0]       rsp_event_kind,
   output logic [2:0]       rsp_event_slot,
   output logic [16:0]      rsp_event_time,
   output logic             rsp_write_accepted,
   output logic [9:0]       rsp_blink_period,
   output logic [10:0]      rsp_tone_freq
);

   localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int WIDE_W     = SLOT_IDX_W + 3;
   localparam logic [SLOT_IDX_W-1:0] LAST_SLOT = SLOT_IDX_W'(SLOT_COUNT - 1);

   state_type state_ff, state_in;

   // Captured transaction
   logic        mode_ff, mode_in;
   logic [16:0] now_ff, now_in;
   logic        ack_ff, ack_in;
   logic [2:0]  num_ff, num_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  minute_ff, minute_in;
   logic [15:0] esc_ff, esc_in;
   logic [15:0] miss_ff, miss_in;
   logic        en_ff, en_in;

   // Scheduler state
   slot_entry_type                 table_ff [SLOT_COUNT];
   logic [SLOT_COUNT-1:0]          enable_ff, enable_in;
   logic [SLOT_COUNT-1:0]          fired_ff, fired_in;
   logic                           alert_run_ff, alert_run_in;
   logic [1:0]                     level_ff, level_in;
   logic [SLOT_IDX_W-1:0]          run_slot_ff, run_slot_in;
   logic [16:0]                    due_ff, due_in;
   logic [16:0]                    prev_ff, prev_in;
   logic [SLOT_IDX_W-1:0]          scan_ff, scan_in;

   // Working result
   logic [1:0]  ev_kind_ff, ev_kind_in;
   logic [2:0]  ev_slot_ff, ev_slot_in;
   logic [16:0] ev_time_ff, ev_time_in;
   logic        accepted_ff, accepted_in;

   // Output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_level_ff, rsp_level_in;
   logic [1:0]  rsp_kind_ff, rsp_kind_in;
   logic [2:0]  rsp_slot_ff, rsp_slot_in;
   logic [16:0] rsp_time_ff, rsp_time_in;
   logic        rsp_acc_ff, rsp_acc_in;

   logic [WIDE_W-1:0]     num_wide;
   logic [SLOT_IDX_W-1:0] wr_idx;
   logic                  wr_ok;
   logic [15:0]           esc_fix;
   logic [15:0]           miss_fix;
   logic [WIDE_W-1:0]     run_wide;
   logic [SLOT_IDX_W-1:0] rd_idx;
   slot_entry_type        rd_entry;
   time_res_type          tres;

   // Decode the slot write
   assign num_wide = {SLOT_IDX_W'(0), num_ff};
   assign wr_idx   = num_wide[SLOT_IDX_W-1:0];
   assign wr_ok    = (num_wide < WIDE_W'(SLOT_COUNT)) && (hour_ff <= HOUR_MAX)
                     && (minute_ff <= MINUTE_MAX);
   assign esc_fix  = (esc_ff == 16'd0) ? ESC_DEFAULT : esc_ff;
   assign miss_fix = (miss_ff <= esc_fix) ? (esc_fix + MISS_EXTRA) : miss_ff;
   assign run_wide = {3'b000, run_slot_ff};

   // Single table read port: running slot on a check, scan slot otherwise
   assign rd_idx   = (state_ff == ST_CHECK) ? run_slot_ff : scan_ff;
   assign rd_entry = table_ff[rd_idx];

   mse_time_unit u_time (
      .now     (now_ff),
      .use_due (state_ff == ST_CHECK),
      .due_run (due_ff),
      .entry   (rd_entry),
      .res     (tres)
   );

   // Sequence one transaction
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      now_in       = now_ff;
      ack_in       = ack_ff;
      num_in       = num_ff;
      hour_in      = hour_ff;
      minute_in    = minute_ff;
      esc_in       = esc_ff;
      miss_in      = miss_ff;
      en_in        = en_ff;
      enable_in    = enable_ff;
      fired_in     = fired_ff;
      alert_run_in = alert_run_ff;
      level_in     = level_ff;
      run_slot_in  = run_slot_ff;
      due_in       = due_ff;
      prev_in      = prev_ff;
      scan_in      = scan_ff;
      ev_kind_in   = ev_kind_ff;
      ev_slot_in   = ev_slot_ff;
      ev_time_in   = ev_time_ff;
      accepted_in  = accepted_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_level_in = rsp_level_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_time_in  = rsp_time_ff;
      rsp_acc_in   = rsp_acc_ff;

      unique case (state_ff)
         ST_IDLE: begin
            // Capture the transaction
            if (req_valid) begin
               mode_in   = req_mode;
               now_in    = req_time_s;
               ack_in    = req_acknowledge;
               num_in    = req_slot_number;
               hour_in   = req_slot_hour;
               minute_in = req_slot_minute;
               esc_in    = req_escalate_delay;
               miss_in   = req_miss_delay;
               en_in     = req_slot_enable;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            ev_kind_in  = EV_NONE;
            ev_slot_in  = 3'd0;
            ev_time_in  = 17'd0;
            accepted_in = 1'b0;
            if (mode_ff) begin
               // Write the slot; the payload goes in through the table port
               if (wr_ok) begin
                  accepted_in       = 1'b1;
                  enable_in[wr_idx] = en_ff;
                  fired_in[wr_idx]  = 1'b0;
               end
               state_in = ST_RESP;
            end else begin
               // Clear fired marks on a new day, record the tick
               if (now_ff < prev_ff) begin
                  fired_in = '0;
               end
               prev_in  = now_ff;
               scan_in  = '0;
               state_in = alert_run_ff ? ST_CHECK : ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Start an alert on the first due slot, else advance
            if (enable_ff[scan_ff] && !fired_ff[scan_ff] && tres.reached) begin
               fired_in[scan_ff] = 1'b1;
               alert_run_in      = 1'b1;
               run_slot_in       = scan_ff;
               due_in            = tres.base;
               level_in          = LVL_ACTIVE;
               state_in          = ST_RESP;
            end else if (scan_ff == LAST_SLOT) begin
               state_in = ST_RESP;
            end else begin
               scan_in = scan_ff + SLOT_IDX_W'(1);
            end
         end
         ST_CHECK: begin
            // Resolve the running alert
            if (ack_ff || tres.past_miss) begin
               if (ack_ff) begin
                  ev_kind_in = tres.within_esc ? EV_ON_TIME : EV_LATE;
               end else begin
                  ev_kind_in = EV_MISSED;
               end
               ev_slot_in   = run_wide[2:0];
               ev_time_in   = now_ff;
               alert_run_in = 1'b0;
               level_in     = LVL_IDLE;
               run_slot_in  = '0;
               due_in       = 17'd0;
            end else begin
               level_in = tres.past_esc ? LVL_ESCALATED : LVL_ACTIVE;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            // Hand the result over once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = level_ff;
               rsp_kind_in  = ev_kind_ff;
               rsp_slot_in  = ev_slot_ff;
               rsp_time_in  = ev_time_ff;
               rsp_acc_in   = accepted_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         enable_ff    <= '0;
         fired_ff     <= '0;
         alert_run_ff <= 1'b0;
         level_ff     <= LVL_IDLE;
         run_slot_ff  <= '0;
         due_ff       <= 17'd0;
         prev_ff      <= 17'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enable_ff    <= enable_in;
         fired_ff     <= fired_in;
         alert_run_ff <= alert_run_in;
         level_ff     <= level_in;
         run_slot_ff  <= run_slot_in;
         due_ff       <= due_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      now_ff       <= now_in;
      ack_ff       <= ack_in;
      num_ff       <= num_in;
      hour_ff      <= hour_in;
      minute_ff    <= minute_in;
      esc_ff       <= esc_in;
      miss_ff      <= miss_in;
      en_ff        <= en_in;
      scan_ff      <= scan_in;
      ev_kind_ff   <= ev_kind_in;
      ev_slot_ff   <= ev_slot_in;
      ev_time_ff   <= ev_time_in;
      accepted_ff  <= accepted_in;
      rsp_level_ff <= rsp_level_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_time_ff  <= rsp_time_in;
      rsp_acc_ff   <= rsp_acc_in;
   end

   // Slot table write port
   always_ff @(posedge clock) begin
      if ((state_ff == ST_EXEC) && mode_ff && wr_ok) begin
         table_ff[wr_idx] <= '{hour: hour_ff, minute: minute_ff, esc: esc_fix, miss: miss_fix};
      end
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_alert_level    = rsp_level_ff;
   assign rsp_event_kind     = rsp_kind_ff;
   assign rsp_event_slot     = rsp_slot_ff;
   assign rsp_event_time     = rsp_time_ff;
   assign rsp_write_accepted = rsp_acc_ff;
   assign rsp_blink_period   = blink_of(rsp_level_ff);
   assign rsp_tone_freq      = tone_of(rsp_level_ff);

   // An event always ends the alert
   `MSE_ASSERT_IMPL(a_event_idle, clock, reset, rsp_valid && (rsp_event_kind != EV_NONE), rsp_alert_level == LVL_IDLE)
   // A write never reports an event
   `MSE_ASSERT_IMPL(a_write_no_event, clock, reset, rsp_valid && rsp_write_accepted, rsp_event_kind == EV_NONE)
   // A running alert always shows a level
   `MSE_ASSERT_IMPL(a_run_level, clock, reset, alert_run_ff, level_ff != LVL_IDLE)
   // An accepted transaction starts execution next cycle
   `MSE_ASSERT_NEXT(a_accept_exec, clock, reset, req_valid && req_ready, state_ff == ST_EXEC)

endmodule
`default_nettype wire

// ===== sim/multi_slot_alarm_escalation_test.sv =====
`timescale 1ns / 100ps
module multi_slot_alarm_escalation_test;
   import mse_pkg::*;

   localparam int SLOTS       = 8;
   localparam int ITEM_TOTAL  = 2000;
   localparam int QUIET_TAIL  = 150;
   localparam int DRAIN       = 40;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int MAX_REPORTS = 10;

   localparam logic MODE_TICK  = 1'b0;
   localparam logic MODE_WRITE = 1'b1;

   typedef struct {
      logic        mode;
      logic [16:0] time_s;
      logic        ack;
      logic [2:0]  slot;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [15:0] esc;
      logic [15:0] miss;
      logic        en;
   } dose_req_type;

   typedef struct {
      logic [1:0]  level;
      logic [1:0]  kind;
      logic [2:0]  slot;
      logic [16:0] at_time;
      logic        accepted;
      logic [9:0]  blink;
      logic [10:0] tone;
   } alarm_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_mode = 1'b0;
   logic [16:0] req_time_s = '0;
   logic        req_acknowledge = 1'b0;
   logic [2:0]  req_slot_number = '0;
   logic [4:0]  req_slot_hour = '0;
   logic [5:0]  req_slot_minute = '0;
   logic [15:0] req_escalate_delay = '0;
   logic [15:0] req_miss_delay = '0;
   logic        req_slot_enable = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_alert_level;
   logic [1:0]  rsp_event_kind;
   logic [2:0]  rsp_event_slot;
   logic [16:0] rsp_event_time;
   logic        rsp_write_accepted;
   logic [9:0]  rsp_blink_period;
   logic [10:0] rsp_tone_freq;

   // Pending stimulus and predicted responses
   dose_req_type  item_queue [$];
   alarm_rsp_type predicted_alerts [$];

   // Shadow of the scheduler state
   logic [4:0]  slot_hour   [SLOTS];
   logic [5:0]  slot_minute [SLOTS];
   logic [15:0] slot_esc    [SLOTS];
   logic [15:0] slot_miss   [SLOTS];
   logic        slot_en     [SLOTS];
   logic        fired       [SLOTS];
   logic        alert_on = 1'b0;
   logic [1:0]  level_now = LVL_IDLE;
   logic [2:0]  run_slot = '0;
   logic [16:0] due_sec = '0;
   logic [16:0] last_tick = '0;

   logic        req_took = 1'b0;
   logic [4:0]  req_gap = '0;
   logic [4:0]  rsp_stall = '0;
   logic [1:0]  idle_odds = 2'd2;
   int          error_count = 0;
   int          cycle_count = 0;

   multi_slot_alarm_escalation u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_time_s         (req_time_s),
      .req_acknowledge    (req_acknowledge),
      .req_slot_number    (req_slot_number),
      .req_slot_hour      (req_slot_hour),
      .req_slot_minute    (req_slot_minute),
      .req_escalate_delay (req_escalate_delay),
      .req_miss_delay     (req_miss_delay),
      .req_slot_enable    (req_slot_enable),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_alert_level    (rsp_alert_level),
      .rsp_event_kind     (rsp_event_kind),
      .rsp_event_slot     (rsp_event_slot),
      .rsp_event_time     (rsp_event_time),
      .rsp_write_accepted (rsp_write_accepted),
      .rsp_blink_period   (rsp_blink_period),
      .rsp_tone_freq      (rsp_tone_freq)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Close the alert and return to idle
   function automatic void end_alert();
      alert_on  = 1'b0;
      level_now = LVL_IDLE;
      run_slot  = '0;
      due_sec   = '0;
   endfunction

   // Advance the shadow scheduler by one transaction and return its response
   function automatic alarm_rsp_type schedule_step(input dose_req_type rq);
      alarm_rsp_type rs;
      int            elapsed;
      int            due;
      logic [15:0]   esc_v;
      logic [15:0]   miss_v;
      logic          started;
      rs.kind     = EV_NONE;
      rs.slot     = '0;
      rs.at_time  = '0;
      rs.accepted = 1'b0;
      if (rq.mode == MODE_WRITE) begin
         if (rq.hour <= HOUR_MAX && rq.minute <= MINUTE_MAX) begin
            esc_v  = (rq.esc == 16'd0) ? ESC_DEFAULT : rq.esc;
            miss_v = (rq.miss <= esc_v) ? esc_v + MISS_EXTRA : rq.miss;
            slot_hour[rq.slot]   = rq.hour;
            slot_minute[rq.slot] = rq.minute;
            slot_esc[rq.slot]    = esc_v;
            slot_miss[rq.slot]   = miss_v;
            slot_en[rq.slot]     = rq.en;
            fired[rq.slot]       = 1'b0;
            rs.accepted          = 1'b1;
         end
      end else begin
         // time running backward means a new day
         if (rq.time_s < last_tick) begin
            for (int i = 0; i < SLOTS; i++) fired[i] = 1'b0;
         end
         last_tick = rq.time_s;
         if (alert_on) begin
            elapsed = (rq.time_s >= due_sec) ? int'(rq.time_s) - int'(due_sec) : 0;
            if (rq.ack) begin
               rs.kind    = (elapsed <= int'(slot_esc[run_slot])) ? EV_ON_TIME : EV_LATE;
               rs.slot    = run_slot;
               rs.at_time = rq.time_s;
               end_alert();
            end else if (elapsed >= int'(slot_miss[run_slot])) begin
               rs.kind    = EV_MISSED;
               rs.slot    = run_slot;
               rs.at_time = rq.time_s;
               end_alert();
            end else begin
               level_now = (elapsed >= int'(slot_esc[run_slot])) ? LVL_ESCALATED : LVL_ACTIVE;
            end
         end else begin
            // pick the lowest enabled slot that is due and not yet fired
            started = 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
               if (!started && slot_en[i] && !fired[i]) begin
                  due = slot_hour[i] * SEC_PER_HOUR + slot_minute[i] * SEC_PER_MINUTE;
                  if (int'(rq.time_s) >= due) begin
                     started   = 1'b1;
                     fired[i]  = 1'b1;
                     alert_on  = 1'b1;
                     run_slot  = 3'(i);
                     due_sec   = 17'(due);
                     level_now = LVL_ACTIVE;
                  end
               end
            end
         end
      end
      rs.level = level_now;
      rs.blink = (level_now == LVL_ACTIVE) ? BLINK_ACTIVE :
                 (level_now == LVL_ESCALATED) ? BLINK_ESCALATED : 10'd0;
      rs.tone  = (level_now == LVL_ACTIVE) ? TONE_ACTIVE :
                 (level_now == LVL_ESCALATED) ? TONE_ESCALATED : 11'd0;
      return rs;
   endfunction

   // Build a transaction with every field random
   function automatic dose_req_type random_req();
      dose_req_type rq;
      rq.mode   = 1'($urandom_range(0, 1));
      rq.time_s = 17'($urandom_range(0, 131071));
      rq.ack    = 1'($urandom_range(0, 1));
      rq.slot   = 3'($urandom_range(0, 7));
      rq.hour   = 5'($urandom_range(0, 31));
      rq.minute = 6'($urandom_range(0, 63));
      rq.esc    = 16'($urandom_range(0, 65535));
      rq.miss   = 16'($urandom_range(0, 65535));
      rq.en     = 1'($urandom_range(0, 1));
      return rq;
   endfunction

   function automatic void add_tick(input logic [16:0] t, input logic ack);
      dose_req_type rq;
      rq        = random_req();
      rq.mode   = MODE_TICK;
      rq.time_s = t;
      rq.ack    = ack;
      item_queue.push_back(rq);
   endfunction

   function automatic void add_write(input logic [2:0] s, input logic [4:0] h,
                                     input logic [5:0] m, input logic [15:0] e,
                                     input logic [15:0] ms, input logic en);
      dose_req_type rq;
      rq        = random_req();
      rq.mode   = MODE_WRITE;
      rq.slot   = s;
      rq.hour   = h;
      rq.minute = m;
      rq.esc    = e;
      rq.miss   = ms;
      rq.en     = en;
      item_queue.push_back(rq);
   endfunction

   // Mostly short delays so that alerts escalate and get missed often
   function automatic logic [15:0] pick_delay();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 16'($urandom_range(1, 300));
      if (pick < 70) return 16'd0;
      return 16'($urandom_range(0, 65535));
   endfunction

   initial begin
      int day_second;
      int pick;
      for (int i = 0; i < SLOTS; i++) begin
         slot_hour[i]   = '0;
         slot_minute[i] = '0;
         slot_esc[i]    = '0;
         slot_miss[i]   = '0;
         slot_en[i]     = 1'b0;
         fired[i]       = 1'b0;
      end

      // Directed: acknowledge while idle, delay defaults, rejected writes
      add_tick(17'd0, 1'b1);
      add_write(3'd0, 5'd0, 6'd0, 16'd0, 16'd0, 1'b1);
      add_write(3'd7, 5'd23, 6'd59, 16'd65535, 16'd65535, 1'b1);
      add_write(3'd3, 5'd24, 6'd0, 16'd10, 16'd20, 1'b1);
      add_write(3'd3, 5'd31, 6'd63, 16'd10, 16'd20, 1'b1);
      add_write(3'd2, 5'd5, 6'd60, 16'd10, 16'd20, 1'b1);
      // Directed: start, escalate, rewrite the running slot, on-time acknowledge
      add_tick(17'd10, 1'b0);
      add_tick(17'd35, 1'b0);
      add_write(3'd0, 5'd0, 6'd0, 16'd100, 16'd200, 1'b1);
      add_tick(17'd50, 1'b0);
      add_tick(17'd60, 1'b1);
      // Directed: refire of the rewritten slot, then a miss
      add_tick(17'd61, 1'b0);
      add_tick(17'd400, 1'b0);
      add_tick(17'd401, 1'b0);
      // Directed: new day while running, time before due, late acknowledge
      add_write(3'd1, 5'd1, 6'd0, 16'd10, 16'd20, 1'b1);
      add_tick(17'd3700, 1'b0);
      add_tick(17'd3590, 1'b0);
      add_tick(17'd3615, 1'b1);
      add_tick(17'd3616, 1'b0);
      // Directed: time beyond the day, disabled slot, wrap to a new day
      add_tick(17'd131071, 1'b0);
      add_tick(17'd131071, 1'b0);
      add_tick(17'd131071, 1'b1);
      add_write(3'd5, 5'd2, 6'd30, 16'd40, 16'd80, 1'b0);
      add_tick(17'd0, 1'b0);

      // Random: populate every slot, then walk through the days
      for (int i = 0; i < SLOTS; i++) begin
         add_write(3'(i), 5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)),
                   pick_delay(), pick_delay(), 1'b1);
      end
      day_second = 0;
      while (item_queue.size() < ITEM_TOTAL) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            add_write(3'($urandom_range(0, 7)),
                      ($urandom_range(0, 99) < 85) ? 5'($urandom_range(0, 23))
                                                   : 5'($urandom_range(24, 31)),
                      ($urandom_range(0, 99) < 85) ? 6'($urandom_range(0, 59))
                                                   : 6'($urandom_range(60, 63)),
                      pick_delay(), pick_delay(), $urandom_range(0, 99) < 80);
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
               day_second += $urandom_range(1, 90);
            end else if (pick < 95) begin
               day_second += $urandom_range(1, 3000);
            end else begin
               day_second = $urandom_range(0, 131071);
            end
            if (pick < 95 && day_second > 86399) day_second -= 86400;
            add_tick(17'(day_second), $urandom_range(0, 99) < 20);
         end
      end

      // Hold reset, then release on a falling edge
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for the stimulus to drain and every response to arrive
      while (item_queue.size() != 0 || req_valid) @(posedge clock);
      while (predicted_alerts.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      if (error_count == 0 && predicted_alerts.size() == 0) begin
         $display("multi_slot_alarm_escalation_test: PASS");
      end else begin
         $display("multi_slot_alarm_escalation_test: FAIL");
      end
      $finish;
   end

   // Drive request transactions on the falling edge
   always @(negedge clock) begin : drive_requests
      dose_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_took) begin
         // hold the transaction until it is taken
      end else if (req_gap != 0) begin
         req_gap   <= req_gap - 5'd1;
         req_valid <= 1'b0;
      end else if (item_queue.size() == 0) begin
         req_valid <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, 8) <= idle_odds) begin
         req_gap   <= 5'($urandom_range(0, 18));
         req_valid <= 1'b0;
      end else begin
         nxt = item_queue.pop_front();
         req_valid          <= 1'b1;
         req_mode           <= nxt.mode;
         req_time_s         <= nxt.time_s;
         req_acknowledge    <= nxt.ack;
         req_slot_number    <= nxt.slot;
         req_slot_hour      <= nxt.hour;
         req_slot_minute    <= nxt.minute;
         req_escalate_delay <= nxt.esc;
         req_miss_delay     <= nxt.miss;
         req_slot_enable    <= nxt.en;
         // change the idling pattern now and then, none near the end
         if (item_queue.size() <= QUIET_TAIL) begin
            idle_odds <= 2'd0;
         end else if (item_queue.size() % 128 == 0) begin
            idle_odds <= 2'($urandom_range(0, 3));
         end
      end
   end

   // Stall the response channel in bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_stall != 0) begin
         rsp_stall <= rsp_stall - 5'd1;
         rsp_ready <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, 10) <= idle_odds) begin
         rsp_stall <= 5'($urandom_range(0, 18));
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Predict on accepted requests, compare accepted responses
   always @(posedge clock) begin : monitor
      dose_req_type  seen;
      alarm_rsp_type want;
      req_took <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            seen.mode   = req_mode;
            seen.time_s = req_time_s;
            seen.ack    = req_acknowledge;
            seen.slot   = req_slot_number;
            seen.hour   = req_slot_hour;
            seen.minute = req_slot_minute;
            seen.esc    = req_escalate_delay;
            seen.miss   = req_miss_delay;
            seen.en     = req_slot_enable;
            predicted_alerts.push_back(schedule_step(seen));
         end
         if (rsp_valid && rsp_ready) begin
            if (predicted_alerts.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("unexpected response: level %0d kind %0d slot %0d",
                           rsp_alert_level, rsp_event_kind, rsp_event_slot);
               end
            end else begin
               want = predicted_alerts.pop_front();
               if (rsp_alert_level !== want.level || rsp_event_kind !== want.kind ||
                   rsp_event_slot !== want.slot || rsp_event_time !== want.at_time ||
                   rsp_write_accepted !== want.accepted ||
                   rsp_blink_period !== want.blink || rsp_tone_freq !== want.tone) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS) begin
                     $display("mismatch at %0t: expected lvl %0d ev %0d slot %0d t %0d acc %0d %0s",
                              $realtime, want.level, want.kind, want.slot, want.at_time,
                              want.accepted, $sformatf("blink %0d tone %0d",
                              want.blink, want.tone));
                     $display("   got lvl %0d ev %0d slot %0d t %0d acc %0d blink %0d tone %0d",
                              rsp_alert_level, rsp_event_kind, rsp_event_slot,
                              rsp_event_time, rsp_write_accepted, rsp_blink_period,
                              rsp_tone_freq);
                  end
               end
            end
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("multi_slot_alarm_escalation_test: FAIL");
         $finish;
      end
   end

endmodule
